// ----- sv/lpt_pkg.sv -----
package lpt_pkg;

  localparam int TableEntriesDef = 128;
  localparam int CoordBitsDef    = 16;

  localparam int RangeW   = 33;
  localparam int CountW   = 8;
  localparam int IndexW   = 7;
  localparam int TagIdxW  = 10;
  localparam int OutDataW = 48;

  localparam logic [RangeW-1:0] EnterRangeRst = 33'd16384;
  localparam logic [RangeW-1:0] ExitRangeRst  = 33'd36864;
  localparam logic [CountW-1:0] StabilityRst  = 8'd5;

  localparam logic [1:0] ModeTick  = 2'd0;
  localparam logic [1:0] ModeWrite = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;
  localparam logic [1:0] ModeReset = 2'd3;

  localparam logic [1:0] RegEnterRange = 2'd0;
  localparam logic [1:0] RegExitRange  = 2'd1;
  localparam logic [1:0] RegStability  = 2'd2;

  // scan tag that travels beside each entry through the distance pipeline
  typedef struct packed {
    logic               vld;
    logic               last;
    logic               ev;
    logic [TagIdxW-1:0] idx;
  } tag_t;

endpackage

// ----- sv/lpt_ram.sv -----
module lpt_ram #(
  parameter int Width = 32,
  parameter int Depth = 128,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/lpt_dist_unit.sv -----
module lpt_dist_unit #(
  parameter int CoordBits = lpt_pkg::CoordBitsDef,
  localparam int DistW = 2 * CoordBits + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [CoordBits-1:0] px_i,
  input  logic signed [CoordBits-1:0] py_i,
  input  logic [2*CoordBits-1:0]      entry_i,
  input  lpt_pkg::tag_t               tag_i,
  output logic [DistW-1:0]            dist_o,
  output lpt_pkg::tag_t               tag_o
);

  logic signed [CoordBits:0]  dx, dy;
  logic [CoordBits-1:0]       ax, ay;
  logic [2*CoordBits-1:0]     sqx_q, sqy_q;
  lpt_pkg::tag_t              tag1_q;

  // entry word holds x in the low half, y in the high half
  always_comb begin
    dx = {px_i[CoordBits-1], px_i} - {entry_i[CoordBits-1], entry_i[CoordBits-1:0]};
    dy = {py_i[CoordBits-1], py_i} -
         {entry_i[2*CoordBits-1], entry_i[2*CoordBits-1:CoordBits]};
    ax = dx[CoordBits] ? CoordBits'(-dx) : dx[CoordBits-1:0];
    ay = dy[CoordBits] ? CoordBits'(-dy) : dy[CoordBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag_o  <= '0;
    end else begin
      tag1_q <= tag_i;
      tag_o  <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sqx_q  <= ax * ax;
    sqy_q  <= ay * ay;
    dist_o <= {1'b0, sqx_q} + {1'b0, sqy_q};
  end

endmodule

// ----- sv/landmark_proximity_tracker_unit.sv -----
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tuser: mode; tdata: index, x, y, gated
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata: fire, spoken, index, distance_sq
// cfg      in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// After a position tick is accepted, its result is formed as follows:
// the scan issues one table read per cycle into a three-stage distance pipeline
// (RAM read, squares, sum), then one shared compare stage and the output register.
// The input is ready again in the same cycle that the result turns valid.
// Write, clear and reset-tracking items go straight from idle to the final state.
// The input side is ready only when no item is in flight; a result waiting on
// m_axis_tready holds the block in its final state.
// Reset clears valid bits and tracking state at once; the coordinate RAM is not
// cleared, since an entry's distance is only used while its valid bit is set.
module landmark_proximity_tracker_unit #(
  parameter int TableEntries = lpt_pkg::TableEntriesDef,
  parameter int CoordBits    = lpt_pkg::CoordBitsDef,
  localparam int InW        = lpt_pkg::IndexW + 2 * CoordBits + 1,
  localparam int InTdataW   = ((InW + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // entry_index, coord_x, coord_y, gated, zero fill
  input  logic [InTdataW-1:0]             s_axis_tdata,
  // mode
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // fire, spoken, landmark_index, distance_sq, zero fill
  output logic [lpt_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [lpt_pkg::RangeW-1:0]      cfg_data_i
);

  localparam int IW    = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int DistW = 2 * CoordBits + 1;
  localparam int CW    = (DistW > lpt_pkg::RangeW) ? DistW : lpt_pkg::RangeW;
  localparam logic [IW-1:0] LastIdx = IW'(TableEntries - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StWait = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0] state_q, state_d;

  // configuration
  logic [lpt_pkg::RangeW-1:0] enter_q, exit_q;
  logic [lpt_pkg::CountW-1:0] stab_q;

  // input unpacking
  logic [1:0]                  in_mode;
  logic [lpt_pkg::IndexW-1:0]  in_idx;
  logic signed [CoordBits-1:0] in_x, in_y;
  logic                        in_gated;
  logic                        s_acc, out_free, fin_go;

  // table and scan
  logic [TableEntries-1:0]     valid_q;
  logic [IW-1:0]               scan_q;
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  logic [2*CoordBits-1:0]      ram_rdata;
  lpt_pkg::tag_t               tag0_q, tag2;
  logic [DistW-1:0]            dist_sq;

  // per-tick working registers
  logic signed [CoordBits-1:0] px_q, py_q;
  logic                        gated_q, is_tick_q;
  logic [CW-1:0]               best_q;
  logic [IW-1:0]               nearest_q;
  logic                        found_q, drop_q;

  // tracking state
  logic                        pend_has_q, last_has_q;
  logic [IW-1:0]               pend_idx_q, last_idx_q;
  logic [lpt_pkg::CountW-1:0]  pend_cnt_q;

  // decision at the end of a tick
  logic                        lh, no_cand, same_pend, fire;
  logic [lpt_pkg::CountW-1:0]  cnt_next;

  // output register
  logic                        out_vld_q;
  logic [lpt_pkg::OutDataW-1:0] out_data_q;

  assign in_mode  = s_axis_tuser;
  assign in_idx   = s_axis_tdata[lpt_pkg::IndexW-1:0];
  assign in_x     = s_axis_tdata[lpt_pkg::IndexW +: CoordBits];
  assign in_y     = s_axis_tdata[lpt_pkg::IndexW + CoordBits +: CoordBits];
  assign in_gated = s_axis_tdata[lpt_pkg::IndexW + 2 * CoordBits];

  assign s_axis_tready = (state_q == StIdle);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign fin_go        = (state_q == StFin) && out_free;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enter_q <= lpt_pkg::EnterRangeRst;
      exit_q  <= lpt_pkg::ExitRangeRst;
      stab_q  <= lpt_pkg::StabilityRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lpt_pkg::RegEnterRange: enter_q <= cfg_data_i;
        lpt_pkg::RegExitRange:  exit_q  <= cfg_data_i;
        lpt_pkg::RegStability:  stab_q  <= cfg_data_i[lpt_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // coordinate store: writes beyond the table are ignored
  assign ram_we    = s_acc && (in_mode == lpt_pkg::ModeWrite) && (int'(in_idx) < TableEntries);
  assign ram_waddr = IW'(in_idx);

  lpt_ram #(
    .Width (2 * CoordBits),
    .Depth (TableEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_y, in_x}),
    .raddr_i (scan_q),
    .rdata_o (ram_rdata)
  );

  lpt_dist_unit #(
    .CoordBits (CoordBits)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .px_i    (px_q),
    .py_i    (py_q),
    .entry_i (ram_rdata),
    .tag_i   (tag0_q),
    .dist_o  (dist_sq),
    .tag_o   (tag2)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (s_acc) state_d = (in_mode == lpt_pkg::ModeTick) ? StScan : StFin;
      StScan: if (scan_q == LastIdx) state_d = StWait;
      StWait: if (tag2.vld && tag2.last) state_d = StFin;
      StFin:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // end-of-tick decision
  always_comb begin
    lh        = last_has_q && !drop_q;
    no_cand   = !found_q || (lh && (nearest_q == last_idx_q));
    same_pend = pend_has_q && (pend_idx_q == nearest_q);
    if (!same_pend) begin
      cnt_next = lpt_pkg::CountW'(1);
    end else if (pend_cnt_q == {lpt_pkg::CountW{1'b1}}) begin
      cnt_next = pend_cnt_q;
    end else begin
      cnt_next = pend_cnt_q + lpt_pkg::CountW'(1);
    end
    fire = is_tick_q && !no_cand && (cnt_next >= stab_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      scan_q     <= '0;
      tag0_q     <= '0;
      valid_q    <= '0;
      pend_has_q <= 1'b0;
      pend_idx_q <= '0;
      pend_cnt_q <= '0;
      last_has_q <= 1'b0;
      last_idx_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // issue one table read per cycle while scanning
      tag0_q.vld  <= (state_q == StScan);
      tag0_q.last <= (scan_q == LastIdx);
      tag0_q.ev   <= valid_q[scan_q];
      tag0_q.idx  <= lpt_pkg::TagIdxW'(scan_q);
      if (state_q == StScan) begin
        scan_q <= (scan_q == LastIdx) ? '0 : scan_q + IW'(1);
      end

      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end

      if (s_acc && (in_mode == lpt_pkg::ModeClear || in_mode == lpt_pkg::ModeReset)) begin
        if (in_mode == lpt_pkg::ModeClear) begin
          valid_q <= '0;
        end
        pend_has_q <= 1'b0;
        pend_idx_q <= '0;
        pend_cnt_q <= '0;
        last_has_q <= 1'b0;
        last_idx_q <= '0;
      end

      // load a new result, or drop the one taken downstream
      if (fin_go) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end

      if (fin_go) begin
        if (is_tick_q) begin
          if (no_cand) begin
            last_has_q <= lh;
            pend_has_q <= 1'b0;
            pend_idx_q <= '0;
            pend_cnt_q <= '0;
          end else if (!fire) begin
            last_has_q <= lh;
            pend_has_q <= 1'b1;
            pend_idx_q <= nearest_q;
            pend_cnt_q <= cnt_next;
          end else begin
            last_has_q <= 1'b1;
            last_idx_q <= nearest_q;
            pend_has_q <= 1'b0;
            pend_idx_q <= '0;
            pend_cnt_q <= '0;
          end
        end
      end
    end
  end

  // per-tick datapath registers and the shared compare stage
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      px_q      <= in_x;
      py_q      <= in_y;
      gated_q   <= in_gated;
      is_tick_q <= (in_mode == lpt_pkg::ModeTick);
      best_q    <= CW'(enter_q);
      nearest_q <= '0;
      found_q   <= 1'b0;
      drop_q    <= 1'b0;
    end else if (tag2.vld) begin
      // strict compare in ascending order keeps the lowest index on ties
      if (tag2.ev && (CW'(dist_sq) < best_q)) begin
        best_q    <= CW'(dist_sq);
        nearest_q <= IW'(tag2.idx);
        found_q   <= 1'b1;
      end
      // re-arm the last announced entry when invalid or beyond exit range
      if (last_has_q && (IW'(tag2.idx) == last_idx_q) &&
          (!tag2.ev || (CW'(dist_sq) > CW'(exit_q)))) begin
        drop_q <= 1'b1;
      end
    end
    if (fin_go) begin
      out_data_q <= fire ? lpt_pkg::OutDataW'({best_q[lpt_pkg::RangeW-1:0],
                                               lpt_pkg::IndexW'(nearest_q),
                                               !gated_q, 1'b1})
                         : '0;
    end
  end

  // assertions
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input accepted while a transaction was in flight");

  a_tag_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag2.vld |-> (state_q == StScan || state_q == StWait))
    else $error("distance result outside a scan");

  a_pend_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_has_q == (pend_cnt_q != '0))
    else $error("pending count disagrees with pending flag");

  a_spoken_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_data_q[1] |-> out_data_q[0])
    else $error("spoken without fire");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin) && !out_free |=> (state_q == StFin))
    else $error("result dropped while output stalled");

endmodule
